// ===== rtl/mwpd_pkg.sv =====
// ----------------------------------------------------------------------------
// mwpd_pkg: shared types, constants and microprogram of the mecanum drive
// Holds the register map, the configuration bundle, the control word layout
// and the read-only program that sequences the shared datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mwpd_pkg;

  // Fixed geometry of the drive.
  localparam int WHEEL_COUNT = 4;
  localparam int WHEEL_W     = $clog2(WHEEL_COUNT);
  localparam int STICK_W     = 11;
  localparam int SPEED_W     = 16;
  localparam int CUR_W       = 16;
  localparam int CENTRE      = 1024;

  // Datapath widths.
  localparam int INTEG_W = 40;               // Q.16 integral accumulator
  localparam int HALF_W  = INTEG_W / 2;      // integral split for the multiplier
  localparam int MA_W    = HALF_W + 1;       // multiplier operand A, signed
  localparam int MB_W    = 23;               // multiplier operand B, signed
  localparam int PROD_W  = MA_W + MB_W;
  localparam int ACC_W   = 60;               // holds a full 40 x 20 bit product

  // Stream and register port widths.
  localparam int IN_TDATA_W  = 112;
  localparam int OUT_TDATA_W = 64;
  localparam int CFG_ADDR_W  = 5;
  localparam int CFG_DATA_W  = 32;

  // Register indexes (byte address is four times the index).
  localparam logic [2:0] REG_KP       = 3'd0;
  localparam logic [2:0] REG_KI       = 3'd1;
  localparam logic [2:0] REG_KD       = 3'd2;
  localparam logic [2:0] REG_LEAK     = 3'd3;
  localparam logic [2:0] REG_ILIM     = 3'd4;
  localparam logic [2:0] REG_OLIM     = 3'd5;
  localparam logic [2:0] REG_DEADBAND = 3'd6;
  localparam logic [2:0] REG_SGAIN    = 3'd7;

  // Register reset values.
  localparam logic [19:0] KP_RST       = 20'd39322;
  localparam logic [19:0] KI_RST       = 20'd7864;
  localparam logic [19:0] KD_RST       = 20'd3932;
  localparam logic [16:0] LEAK_RST     = 17'd62259;
  localparam logic [17:0] ILIM_RST     = 18'd10000;
  localparam logic [14:0] OLIM_RST     = 15'd10000;
  localparam logic [9:0]  DEADBAND_RST = 10'd45;
  localparam logic [21:0] SGAIN_RST    = 22'd595782;

  typedef struct packed {
    logic [19:0] kp;
    logic [19:0] ki;
    logic [19:0] kd;
    logic [16:0] leak;
    logic [17:0] ilim;
    logic [14:0] olim;
    logic [9:0]  deadband;
    logic [21:0] sgain;
  } cfg_t;

  // Multiplier operand A sources.
  localparam logic [2:0] A_NONE = 3'd0;
  localparam logic [2:0] A_STR  = 3'd1;
  localparam logic [2:0] A_DRV  = 3'd2;
  localparam logic [2:0] A_ROT  = 3'd3;
  localparam logic [2:0] A_ILO  = 3'd4;
  localparam logic [2:0] A_IHI  = 3'd5;
  localparam logic [2:0] A_ERR  = 3'd6;
  localparam logic [2:0] A_DER  = 3'd7;

  // Multiplier operand B sources.
  localparam logic [2:0] B_NONE  = 3'd0;
  localparam logic [2:0] B_SGAIN = 3'd1;
  localparam logic [2:0] B_LEAK  = 3'd2;
  localparam logic [2:0] B_KI    = 3'd3;
  localparam logic [2:0] B_KP    = 3'd4;
  localparam logic [2:0] B_KD    = 3'd5;

  // Use of the product registered in the previous step.
  localparam logic [2:0] P_NONE   = 3'd0;
  localparam logic [2:0] P_STR    = 3'd1;
  localparam logic [2:0] P_DRV    = 3'd2;
  localparam logic [2:0] P_ROT    = 3'd3;
  localparam logic [2:0] P_LOAD   = 3'd4;
  localparam logic [2:0] P_ADDHI  = 3'd5;
  localparam logic [2:0] P_Q16ADD = 3'd6;
  localparam logic [2:0] P_ADD    = 3'd7;

  // Other datapath operations.
  localparam logic [2:0] X_NONE   = 3'd0;
  localparam logic [2:0] X_SETP   = 3'd1;
  localparam logic [2:0] X_ERR    = 3'd2;
  localparam logic [2:0] X_INTEG  = 3'd3;
  localparam logic [2:0] X_LEAKQ  = 3'd4;
  localparam logic [2:0] X_FINISH = 3'd5;
  localparam logic [2:0] X_EMIT   = 3'd6;

  // Sequencing.
  localparam logic [2:0] J_NEXT    = 3'd0;
  localparam logic [2:0] J_WAIT_IN = 3'd1;
  localparam logic [2:0] J_SP_ZERO = 3'd2;
  localparam logic [2:0] J_MORE    = 3'd3;
  localparam logic [2:0] J_EMIT    = 3'd4;
  localparam logic [2:0] J_GOTO    = 3'd5;

  localparam int STEP_W = 5;

  localparam logic [STEP_W-1:0] ST_WAIT      = 5'd0;
  localparam logic [STEP_W-1:0] ST_MUL_STR   = 5'd1;
  localparam logic [STEP_W-1:0] ST_MUL_DRV   = 5'd2;
  localparam logic [STEP_W-1:0] ST_MUL_ROT   = 5'd3;
  localparam logic [STEP_W-1:0] ST_STICK_END = 5'd4;
  localparam logic [STEP_W-1:0] ST_SETP      = 5'd5;
  localparam logic [STEP_W-1:0] ST_ERR       = 5'd6;
  localparam logic [STEP_W-1:0] ST_INTEG     = 5'd7;
  localparam logic [STEP_W-1:0] ST_LEAK_LO   = 5'd8;
  localparam logic [STEP_W-1:0] ST_LEAK_HI   = 5'd9;
  localparam logic [STEP_W-1:0] ST_LEAK_ADD  = 5'd10;
  localparam logic [STEP_W-1:0] ST_LEAK_Q    = 5'd11;
  localparam logic [STEP_W-1:0] ST_KI_LO     = 5'd12;
  localparam logic [STEP_W-1:0] ST_KI_HI     = 5'd13;
  localparam logic [STEP_W-1:0] ST_KP        = 5'd14;
  localparam logic [STEP_W-1:0] ST_KD        = 5'd15;
  localparam logic [STEP_W-1:0] ST_SUM_END   = 5'd16;
  localparam logic [STEP_W-1:0] ST_FINISH    = 5'd17;
  localparam logic [STEP_W-1:0] ST_EMIT      = 5'd18;

  typedef struct packed {
    logic [2:0]        a_sel;
    logic [2:0]        b_sel;
    logic [2:0]        post;
    logic [2:0]        exec;
    logic [2:0]        jcond;
    logic [STEP_W-1:0] target;
  } ucode_t;

  function automatic ucode_t uc(input logic [2:0] a, input logic [2:0] b,
                                input logic [2:0] p, input logic [2:0] x,
                                input logic [2:0] j, input logic [STEP_W-1:0] t);
    ucode_t w;
    w.a_sel  = a;
    w.b_sel  = b;
    w.post   = p;
    w.exec   = x;
    w.jcond  = j;
    w.target = t;
    return w;
  endfunction

  // The program: stick scaling, mixing, then one PID pass per wheel.
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    unique case (step)
      ST_WAIT:      w = uc(A_NONE, B_NONE,  P_NONE,   X_NONE,   J_WAIT_IN, ST_WAIT);
      ST_MUL_STR:   w = uc(A_STR,  B_SGAIN, P_NONE,   X_NONE,   J_NEXT,    ST_WAIT);
      ST_MUL_DRV:   w = uc(A_DRV,  B_SGAIN, P_STR,    X_NONE,   J_NEXT,    ST_WAIT);
      ST_MUL_ROT:   w = uc(A_ROT,  B_SGAIN, P_DRV,    X_NONE,   J_NEXT,    ST_WAIT);
      ST_STICK_END: w = uc(A_NONE, B_NONE,  P_ROT,    X_NONE,   J_NEXT,    ST_WAIT);
      ST_SETP:      w = uc(A_NONE, B_NONE,  P_NONE,   X_SETP,   J_NEXT,    ST_WAIT);
      ST_ERR:       w = uc(A_NONE, B_NONE,  P_NONE,   X_ERR,    J_NEXT,    ST_WAIT);
      ST_INTEG:     w = uc(A_NONE, B_NONE,  P_NONE,   X_INTEG,  J_SP_ZERO, ST_KI_LO);
      ST_LEAK_LO:   w = uc(A_ILO,  B_LEAK,  P_NONE,   X_NONE,   J_NEXT,    ST_WAIT);
      ST_LEAK_HI:   w = uc(A_IHI,  B_LEAK,  P_LOAD,   X_NONE,   J_NEXT,    ST_WAIT);
      ST_LEAK_ADD:  w = uc(A_NONE, B_NONE,  P_ADDHI,  X_NONE,   J_NEXT,    ST_WAIT);
      ST_LEAK_Q:    w = uc(A_NONE, B_NONE,  P_NONE,   X_LEAKQ,  J_NEXT,    ST_WAIT);
      ST_KI_LO:     w = uc(A_ILO,  B_KI,    P_NONE,   X_NONE,   J_NEXT,    ST_WAIT);
      ST_KI_HI:     w = uc(A_IHI,  B_KI,    P_LOAD,   X_NONE,   J_NEXT,    ST_WAIT);
      ST_KP:        w = uc(A_ERR,  B_KP,    P_ADDHI,  X_NONE,   J_NEXT,    ST_WAIT);
      ST_KD:        w = uc(A_DER,  B_KD,    P_Q16ADD, X_NONE,   J_NEXT,    ST_WAIT);
      ST_SUM_END:   w = uc(A_NONE, B_NONE,  P_ADD,    X_NONE,   J_NEXT,    ST_WAIT);
      ST_FINISH:    w = uc(A_NONE, B_NONE,  P_NONE,   X_FINISH, J_MORE,    ST_ERR);
      ST_EMIT:      w = uc(A_NONE, B_NONE,  P_NONE,   X_EMIT,   J_EMIT,    ST_WAIT);
      default:      w = uc(A_NONE, B_NONE,  P_NONE,   X_NONE,   J_GOTO,    ST_WAIT);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mecanum_wheel_pid_drive.sv =====
// ----------------------------------------------------------------------------
// mecanum_wheel_pid_drive: mecanum mixing with four PID speed loops
// Each item runs through 5 stick steps, then 8 (setpoint zero, no leak) or
// 12 steps per wheel on the one shared multiplier, then one output step,
// which waits while the output register still holds an untaken result. The
// next input is taken the cycle after the result is loaded.
// Reset (synchronous, rst_n low) clears integrals, last errors and control.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// A microcoded sequencer drives a small datapath built around a single
// registered multiplier. Each control word selects the two multiplier
// operands, what to do with the product registered in the step before, one
// other datapath operation, and how to continue (next step, wait, or jump).
//
// The integral is a 40 bit signed Q.16 value. Products with it are split
// into a low unsigned half and a high signed half, giving two partial
// products that the accumulator combines over two steps.
//
// An output register holds the finished result, so a new item can be
// taken while the previous result still waits for its transfer.

module mecanum_wheel_pid_drive (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // in_tdata, lowest bit first: stick_strafe[10:0], stick_drive[21:11],
  // stick_rotate[32:22], stop_level[43:33], speed_fl[59:44],
  // speed_fr[75:60], speed_bl[91:76], speed_br[107:92], zero fill [111:108]
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  input  wire logic [mwpd_pkg::IN_TDATA_W-1:0]      in_tdata,
  // out_tdata, lowest bit first: current_fl[15:0], current_fr[31:16],
  // current_bl[47:32], current_br[63:48]
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  output logic [mwpd_pkg::OUT_TDATA_W-1:0]          out_tdata,
  input  wire logic                                 cfg_psel,
  input  wire logic                                 cfg_penable,
  input  wire logic                                 cfg_pwrite,
  input  wire logic [mwpd_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  wire logic [mwpd_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic      [mwpd_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                      cfg_pready
);
  import mwpd_pkg::*;

  // Round toward zero while dropping 16 fractional bits.
  function automatic logic signed [ACC_W-1:0] q16(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] t;
    t = v + $signed({{(ACC_W-16){1'b0}}, {16{v[ACC_W-1]}}});
    return t >>> 16;
  endfunction

  function automatic logic signed [SPEED_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(32767);
    lo = -ACC_W'(32768);
    if (v > hi) begin
      return 16'sh7fff;
    end else if (v < lo) begin
      return 16'sh8000;
    end
    return v[SPEED_W-1:0];
  endfunction

  // Offset from the stick centre with the deadband applied.
  function automatic logic signed [MA_W-1:0] stick_offset(input logic [STICK_W-1:0] raw,
                                                          input logic [9:0] db);
    logic signed [11:0] d;
    logic signed [11:0] dbs;
    d   = $signed({1'b0, raw}) - $signed(12'(CENTRE));
    dbs = $signed({2'b00, db});
    if ((d > -dbs) && (d < dbs)) begin
      d = '0;
    end
    return {{(MA_W-12){d[11]}}, d};
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  cfg_t cfg;

  mwpd_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // --------------------------------------------------------------------------
  // Sequencer and datapath registers
  // --------------------------------------------------------------------------
  logic [STEP_W-1:0]         pc_r, pc_nxt;
  logic [WHEEL_W-1:0]        wheel_r, wheel_nxt;
  ucode_t                    uw;

  // Captured input item.
  logic [STICK_W-1:0]        str_raw_r, drv_raw_r, rot_raw_r, stop_raw_r;
  logic signed [SPEED_W-1:0] speed_r [WHEEL_COUNT];

  logic signed [SPEED_W-1:0] str_r, str_nxt;
  logic signed [SPEED_W-1:0] drv_r, drv_nxt;
  logic signed [SPEED_W-1:0] rot_r, rot_nxt;
  logic signed [SPEED_W-1:0] sp_r [WHEEL_COUNT];
  logic signed [SPEED_W-1:0] sp_nxt [WHEEL_COUNT];
  logic signed [SPEED_W-1:0] err_r, err_nxt;
  logic signed [SPEED_W-1:0] der_r, der_nxt;
  logic signed [INTEG_W-1:0] integ_r, integ_nxt;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic signed [CUR_W-1:0]   cmd_r [WHEEL_COUNT];
  logic signed [CUR_W-1:0]   cmd_nxt [WHEEL_COUNT];

  // Per-wheel loop state.
  logic signed [INTEG_W-1:0] integ_acc_r [WHEEL_COUNT];
  logic signed [INTEG_W-1:0] integ_acc_nxt [WHEEL_COUNT];
  logic signed [SPEED_W-1:0] last_err_r [WHEEL_COUNT];
  logic signed [SPEED_W-1:0] last_err_nxt [WHEEL_COUNT];

  logic                      out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0]    out_tdata_r;

  logic                      in_fire;
  logic                      out_busy;
  logic                      emit_en;

  assign uw        = ucode_rom(pc_r);
  assign in_tready = (pc_r == ST_WAIT);
  assign in_fire   = in_tvalid && in_tready;
  assign out_busy  = out_tvalid_r && !out_tready;
  assign emit_en   = (uw.exec == X_EMIT) && !out_busy;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // --------------------------------------------------------------------------
  // Shared multiplier and its operand selection
  // --------------------------------------------------------------------------
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  prod_ext;

  always_comb begin
    unique case (uw.a_sel)
      A_STR:   mul_a = stick_offset(str_raw_r, cfg.deadband);
      A_DRV:   mul_a = stick_offset(drv_raw_r, cfg.deadband);
      A_ROT:   mul_a = stick_offset(rot_raw_r, cfg.deadband);
      A_ILO:   mul_a = {1'b0, integ_r[HALF_W-1:0]};
      A_IHI:   mul_a = {integ_r[INTEG_W-1], integ_r[INTEG_W-1:HALF_W]};
      A_ERR:   mul_a = MA_W'(err_r);
      A_DER:   mul_a = MA_W'(der_r);
      default: mul_a = '0;
    endcase
  end

  always_comb begin
    unique case (uw.b_sel)
      B_SGAIN: mul_b = {1'b0, cfg.sgain};
      B_LEAK:  mul_b = {6'b0, cfg.leak};
      B_KI:    mul_b = {3'b0, cfg.ki};
      B_KP:    mul_b = {3'b0, cfg.kp};
      B_KD:    mul_b = {3'b0, cfg.kd};
      default: mul_b = '0;
    endcase
  end

  mwpd_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod)
  );

  assign prod_ext = ACC_W'(prod);

  // --------------------------------------------------------------------------
  // Arithmetic around the multiplier
  // --------------------------------------------------------------------------
  logic signed [SPEED_W-1:0] stick_scaled;
  logic signed [ACC_W-1:0]   acc_q16;
  logic signed [17:0]        s_str, s_drv, s_rot;
  logic signed [17:0]        sum_fl, sum_fr, sum_bl, sum_br;
  logic                      stop;
  logic signed [SPEED_W-1:0] sp_w, spd_w, lerr_w;
  logic signed [INTEG_W-1:0] iacc_w;
  logic signed [16:0]        err_diff, der_diff, der_sum;
  logic signed [ACC_W-1:0]   olim_s;
  logic signed [ACC_W-1:0]   cmd_full;
  logic signed [CUR_W-1:0]   cmd_clamped;
  logic signed [INTEG_W-1:0] ilim_s;
  logic signed [INTEG_W-1:0] integ_clamped;

  assign stick_scaled = sat16(q16(prod_ext));
  assign acc_q16      = q16(acc_r);

  // Mecanum mixing; sums are 18 bits wide so they cannot wrap before the
  // saturation.
  assign s_str  = 18'(str_r);
  assign s_drv  = 18'(drv_r);
  assign s_rot  = 18'(rot_r);
  assign sum_fl = s_drv + s_str + s_rot;
  assign sum_fr = -s_drv + s_str + s_rot;
  assign sum_bl = s_drv - s_str + s_rot;
  assign sum_br = -s_drv - s_str + s_rot;
  assign stop   = (stop_raw_r > STICK_W'(CENTRE));

  assign sp_w   = sp_r[wheel_r];
  assign spd_w  = speed_r[wheel_r];
  assign lerr_w = last_err_r[wheel_r];
  assign iacc_w = integ_acc_r[wheel_r];

  assign err_diff = 17'(sp_w) - 17'(spd_w);

  // Difference halved with rounding toward zero.
  assign der_diff = 17'(err_r) - 17'(lerr_w);
  assign der_sum  = der_diff + $signed({16'b0, der_diff[16]});

  assign olim_s   = $signed({{(ACC_W-15){1'b0}}, cfg.olim});
  assign cmd_full = acc_q16;

  always_comb begin
    if (cmd_full > olim_s) begin
      cmd_clamped = olim_s[CUR_W-1:0];
    end else if (cmd_full < -olim_s) begin
      cmd_clamped = CUR_W'(-olim_s);
    end else begin
      cmd_clamped = cmd_full[CUR_W-1:0];
    end
  end

  // The integral limit is an integer, so it sits above 16 fraction bits.
  assign ilim_s = $signed({{(INTEG_W-34){1'b0}}, cfg.ilim, 16'b0});

  always_comb begin
    if (integ_r > ilim_s) begin
      integ_clamped = ilim_s;
    end else if (integ_r < -ilim_s) begin
      integ_clamped = -ilim_s;
    end else begin
      integ_clamped = integ_r;
    end
  end

  // --------------------------------------------------------------------------
  // Next-state logic driven by the control word
  // --------------------------------------------------------------------------
  always_comb begin
    pc_nxt         = pc_r + 1'b1;
    wheel_nxt      = wheel_r;
    str_nxt        = str_r;
    drv_nxt        = drv_r;
    rot_nxt        = rot_r;
    sp_nxt         = sp_r;
    err_nxt        = err_r;
    der_nxt        = der_r;
    integ_nxt      = integ_r;
    acc_nxt        = acc_r;
    cmd_nxt        = cmd_r;
    integ_acc_nxt  = integ_acc_r;
    last_err_nxt   = last_err_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;

    case (uw.post)
      P_STR:    str_nxt = stick_scaled;
      P_DRV:    drv_nxt = stick_scaled;
      P_ROT:    rot_nxt = stick_scaled;
      P_LOAD:   acc_nxt = prod_ext;
      P_ADDHI:  acc_nxt = acc_r + (prod_ext <<< HALF_W);
      P_Q16ADD: acc_nxt = acc_q16 + prod_ext;
      P_ADD:    acc_nxt = acc_r + prod_ext;
      default:  acc_nxt = acc_r;
    endcase

    case (uw.exec)
      X_SETP: begin
        if (stop) begin
          for (int i = 0; i < WHEEL_COUNT; i++) begin
            sp_nxt[i] = '0;
          end
        end else begin
          sp_nxt[0] = sat16(ACC_W'(sum_fl));
          sp_nxt[1] = sat16(ACC_W'(sum_fr));
          sp_nxt[2] = sat16(ACC_W'(sum_bl));
          sp_nxt[3] = sat16(ACC_W'(sum_br));
        end
        wheel_nxt = '0;
      end
      X_ERR: begin
        err_nxt = sat16(ACC_W'(err_diff));
      end
      X_INTEG: begin
        // The error enters the integral times two, in Q.16.
        integ_nxt = iacc_w + (INTEG_W'(err_r) <<< 17);
        der_nxt   = 16'(der_sum >>> 1);
      end
      X_LEAKQ: begin
        integ_nxt = acc_q16[INTEG_W-1:0];
      end
      X_FINISH: begin
        cmd_nxt[wheel_r]       = cmd_clamped;
        integ_acc_nxt[wheel_r] = integ_clamped;
        last_err_nxt[wheel_r]  = err_r;
        wheel_nxt              = wheel_r + 1'b1;
      end
      X_EMIT: begin
        if (emit_en) begin
          out_tvalid_nxt = 1'b1;
        end
      end
      default: begin
        wheel_nxt = wheel_r;
      end
    endcase

    case (uw.jcond)
      J_WAIT_IN: begin
        if (!in_fire) begin
          pc_nxt = pc_r;
        end
      end
      J_SP_ZERO: begin
        // No leak while the setpoint is zero.
        if (sp_w == '0) begin
          pc_nxt = uw.target;
        end
      end
      J_MORE: begin
        if (wheel_r != WHEEL_W'(WHEEL_COUNT - 1)) begin
          pc_nxt = uw.target;
        end
      end
      J_EMIT: begin
        pc_nxt = out_busy ? pc_r : uw.target;
      end
      J_GOTO: begin
        pc_nxt = uw.target;
      end
      default: begin
        pc_nxt = pc_r + 1'b1;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r         <= ST_WAIT;
      wheel_r      <= '0;
      out_tvalid_r <= 1'b0;
      for (int i = 0; i < WHEEL_COUNT; i++) begin
        integ_acc_r[i] <= '0;
        last_err_r[i]  <= '0;
      end
    end else begin
      pc_r         <= pc_nxt;
      wheel_r      <= wheel_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      integ_acc_r  <= integ_acc_nxt;
      last_err_r   <= last_err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      str_raw_r  <= in_tdata[10:0];
      drv_raw_r  <= in_tdata[21:11];
      rot_raw_r  <= in_tdata[32:22];
      stop_raw_r <= in_tdata[43:33];
      speed_r[0] <= in_tdata[59:44];
      speed_r[1] <= in_tdata[75:60];
      speed_r[2] <= in_tdata[91:76];
      speed_r[3] <= in_tdata[107:92];
    end
    if (emit_en) begin
      out_tdata_r <= {cmd_r[3], cmd_r[2], cmd_r[1], cmd_r[0]};
    end
    str_r   <= str_nxt;
    drv_r   <= drv_nxt;
    rot_r   <= rot_nxt;
    sp_r    <= sp_nxt;
    err_r   <= err_nxt;
    der_r   <= der_nxt;
    integ_r <= integ_nxt;
    acc_r   <= acc_nxt;
    cmd_r   <= cmd_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/mwpd_mul.sv =====
// ----------------------------------------------------------------------------
// mwpd_mul: shared signed multiplier
// One signed product per cycle, registered at the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mwpd_mul (
  input  wire logic                                clk,
  input  wire logic signed [mwpd_pkg::MA_W-1:0]    op_a,
  input  wire logic signed [mwpd_pkg::MB_W-1:0]    op_b,
  output logic signed [mwpd_pkg::PROD_W-1:0]       prod_r
);
  import mwpd_pkg::*;

  logic signed [PROD_W-1:0] prod_nxt;

  assign prod_nxt = PROD_W'(op_a) * PROD_W'(op_b);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/mwpd_cfg.sv =====
// ----------------------------------------------------------------------------
// mwpd_cfg: configuration register file
// APB-style write and read access to the eight gain and limit registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mwpd_cfg (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_psel,
  input  wire logic                                cfg_penable,
  input  wire logic                                cfg_pwrite,
  input  wire logic [mwpd_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  wire logic [mwpd_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic      [mwpd_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                     cfg_pready,
  output mwpd_pkg::cfg_t                           cfg
);
  import mwpd_pkg::*;

  cfg_t       regs_r;
  cfg_t       regs_nxt;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[CFG_ADDR_W-1:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg        = regs_r;

  always_comb begin
    regs_nxt = regs_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_KP:       regs_nxt.kp       = cfg_pwdata[19:0];
        REG_KI:       regs_nxt.ki       = cfg_pwdata[19:0];
        REG_KD:       regs_nxt.kd       = cfg_pwdata[19:0];
        REG_LEAK:     regs_nxt.leak     = cfg_pwdata[16:0];
        REG_ILIM:     regs_nxt.ilim     = cfg_pwdata[17:0];
        REG_OLIM:     regs_nxt.olim     = cfg_pwdata[14:0];
        REG_DEADBAND: regs_nxt.deadband = cfg_pwdata[9:0];
        REG_SGAIN:    regs_nxt.sgain    = cfg_pwdata[21:0];
        default:      regs_nxt = regs_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_KP:       cfg_prdata = CFG_DATA_W'(regs_r.kp);
      REG_KI:       cfg_prdata = CFG_DATA_W'(regs_r.ki);
      REG_KD:       cfg_prdata = CFG_DATA_W'(regs_r.kd);
      REG_LEAK:     cfg_prdata = CFG_DATA_W'(regs_r.leak);
      REG_ILIM:     cfg_prdata = CFG_DATA_W'(regs_r.ilim);
      REG_OLIM:     cfg_prdata = CFG_DATA_W'(regs_r.olim);
      REG_DEADBAND: cfg_prdata = CFG_DATA_W'(regs_r.deadband);
      REG_SGAIN:    cfg_prdata = CFG_DATA_W'(regs_r.sgain);
      default:      cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.kp       <= KP_RST;
      regs_r.ki       <= KI_RST;
      regs_r.kd       <= KD_RST;
      regs_r.leak     <= LEAK_RST;
      regs_r.ilim     <= ILIM_RST;
      regs_r.olim     <= OLIM_RST;
      regs_r.deadband <= DEADBAND_RST;
      regs_r.sgain    <= SGAIN_RST;
    end else begin
      regs_r <= regs_nxt;
    end
  end

endmodule

`default_nettype wire
